### rtl/core/stcs_pkg.sv
package stcs_pkg;

    // Command codes
    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_STOP  = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;

    // Link status codes
    localparam logic [1:0] ST_WAIT = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    // Job kinds handed from front to back
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_ENABLE = 3'd1;
    localparam logic [2:0] KIND_STOP   = 3'd2;
    localparam logic [2:0] KIND_SYNC   = 3'd3;
    localparam logic [2:0] KIND_POS    = 3'd4;

    // Register indexes on the config port
    localparam logic [2:0] REG_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_TRAVEL   = 3'd1;
    localparam logic [2:0] REG_STOPSET  = 3'd2;
    localparam logic [2:0] REG_GAP      = 3'd3;
    localparam logic [2:0] REG_ADDR     = 3'd4;
    localparam logic [2:0] REG_SPEED    = 3'd5;
    localparam logic [2:0] REG_PULSES   = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_TIMEOUT = 16'd2000;
    localparam logic [15:0] RST_TRAVEL  = 16'd840;
    localparam logic [15:0] RST_STOPSET = 16'd2;
    localparam logic [7:0]  RST_GAP     = 8'd2;
    localparam logic [7:0]  RST_ADDR    = 8'd5;
    localparam logic [15:0] RST_SPEED   = 16'd1000;
    localparam logic [31:0] RST_PULSES  = 32'd1280;

    // Frame bytes
    localparam logic [7:0] B_ZERO     = 8'h00;
    localparam logic [7:0] B_ONE      = 8'h01;
    localparam logic [7:0] B_TAIL     = 8'h6b;
    localparam logic [7:0] B_EN_CMD   = 8'hf3;
    localparam logic [7:0] B_EN_SUB   = 8'hab;
    localparam logic [7:0] B_STOP_CMD = 8'hfe;
    localparam logic [7:0] B_STOP_SUB = 8'h98;
    localparam logic [7:0] B_SYNC_CMD = 8'hff;
    localparam logic [7:0] B_SYNC_SUB = 8'h66;
    localparam logic [7:0] B_POS_CMD  = 8'hfd;

    // Queue depths
    localparam int STCS_JOB_DEPTH = 2;
    localparam int STCS_OUT_DEPTH = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic       dir;
        logic [1:0] status;
        logic       busy;
        logic       accepted;
    } t_job;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       byte_valid;
        logic       last_item;
        logic [1:0] status;
        logic       start_accepted;
        logic       busy_res;
    } t_res;

    // Number of results a job produces
    function automatic logic [3:0] frame_len(input logic [2:0] kind);
        logic [3:0] len;
        case (kind)
            KIND_ENABLE: len = 4'd6;
            KIND_STOP:   len = 4'd5;
            KIND_SYNC:   len = 4'd4;
            KIND_POS:    len = 4'd13;
            default:     len = 4'd1;
        endcase
        return len;
    endfunction

    // Byte at position idx of a frame
    function automatic logic [7:0] frame_byte(
        input logic [2:0]  kind,
        input logic [3:0]  idx,
        input logic [7:0]  addr,
        input logic        dir,
        input logic [15:0] speed,
        input logic [31:0] pulses
    );
        logic [7:0] b;
        b = B_ZERO;
        case (kind)
            KIND_ENABLE: begin
                case (idx)
                    4'd0:    b = addr;
                    4'd1:    b = B_EN_CMD;
                    4'd2:    b = B_EN_SUB;
                    4'd3:    b = B_ONE;
                    4'd4:    b = B_ONE;
                    default: b = B_TAIL;
                endcase
            end
            KIND_STOP: begin
                case (idx)
                    4'd0:    b = addr;
                    4'd1:    b = B_STOP_CMD;
                    4'd2:    b = B_STOP_SUB;
                    4'd3:    b = B_ONE;
                    default: b = B_TAIL;
                endcase
            end
            KIND_SYNC: begin
                case (idx)
                    4'd0:    b = B_ZERO;
                    4'd1:    b = B_SYNC_CMD;
                    4'd2:    b = B_SYNC_SUB;
                    default: b = B_TAIL;
                endcase
            end
            KIND_POS: begin
                case (idx)
                    4'd0:    b = addr;
                    4'd1:    b = B_POS_CMD;
                    4'd2:    b = {7'd0, dir};
                    4'd3:    b = speed[15:8];
                    4'd4:    b = speed[7:0];
                    4'd5:    b = B_ZERO;
                    4'd6:    b = pulses[31:24];
                    4'd7:    b = pulses[23:16];
                    4'd8:    b = pulses[15:8];
                    4'd9:    b = pulses[7:0];
                    4'd10:   b = B_ZERO;
                    4'd11:   b = B_ONE;
                    default: b = B_TAIL;
                endcase
            end
            default: b = B_ZERO;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/stcs_fifo.sv
module stcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/core/stcs_front.sv
module stcs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_func,
    input  logic               i_reverse,
    input  logic [31:0]        i_now_ms,
    input  logic               i_link_idle,
    input  logic               i_tx_accept,
    input  logic [15:0]        i_timeout_ms,
    input  logic [15:0]        i_travel_settle_ms,
    input  logic [15:0]        i_stop_settle_ms,
    input  logic [7:0]         i_frame_gap_ms,
    output stcs_pkg::t_job     o_job,
    output logic               o_job_push,
    input  logic               i_job_full
);
    import stcs_pkg::*;

    logic        r_busy, r_stop_mode, r_await, r_settle, r_rev;
    logic [2:0]  r_fcount;
    logic [31:0] r_start_stamp, r_frame_stamp;
    logic [1:0]  r_status;

    logic        n_busy, n_stop_mode, n_await, n_settle, n_rev;
    logic [2:0]  n_fcount;
    logic [31:0] n_start_stamp, n_frame_stamp;
    logic [1:0]  n_status;

    logic        w_take;
    logic [31:0] w_elapsed, w_since;
    logic [15:0] w_settle_ms;
    logic        w_timed_out, w_gap_ok, w_settle_done, w_last_frame;
    logic [2:0]  w_fcount_inc;
    logic [2:0]  w_kind, w_frame_kind;
    logic        w_accepted;

    assign w_take     = i_push && !i_job_full;
    assign o_full     = i_job_full;
    assign o_job_push = w_take;

    // timer compares, all modulo 2^32
    assign w_elapsed     = i_now_ms - r_start_stamp;
    assign w_since       = i_now_ms - r_frame_stamp;
    assign w_settle_ms   = r_stop_mode ? i_stop_settle_ms : i_travel_settle_ms;
    assign w_timed_out   = (w_elapsed >= {16'd0, i_timeout_ms});
    assign w_gap_ok      = (r_fcount == 3'd0) || (w_since >= {24'd0, i_frame_gap_ms});
    assign w_settle_done = (w_since >= {16'd0, w_settle_ms});
    assign w_fcount_inc  = r_fcount + 3'd1;
    assign w_last_frame  = (w_fcount_inc == (r_stop_mode ? 3'd2 : 3'd4));

    // which frame is next in the sequence
    always_comb begin
        if (r_fcount[0]) begin
            w_frame_kind = KIND_SYNC;
        end else if (r_stop_mode) begin
            w_frame_kind = KIND_STOP;
        end else if (r_fcount == 3'd0) begin
            w_frame_kind = KIND_ENABLE;
        end else begin
            w_frame_kind = KIND_POS;
        end
    end

    // command classification and sequencer next state
    always_comb begin
        n_busy        = r_busy;
        n_stop_mode   = r_stop_mode;
        n_await       = r_await;
        n_settle      = r_settle;
        n_rev         = r_rev;
        n_fcount      = r_fcount;
        n_start_stamp = r_start_stamp;
        n_frame_stamp = r_frame_stamp;
        n_status      = r_status;
        w_kind        = KIND_NONE;
        w_accepted    = 1'b0;
        case (i_func)
            FN_START: begin
                if (!r_busy && r_status != ST_FAIL) begin
                    w_accepted    = 1'b1;
                    n_rev         = i_reverse;
                    n_start_stamp = i_now_ms;
                    n_fcount      = 3'd0;
                    n_busy        = 1'b1;
                    n_stop_mode   = 1'b0;
                    n_await       = 1'b0;
                    n_settle      = 1'b0;
                    n_status      = ST_WAIT;
                end
            end
            FN_STOP: begin
                n_start_stamp = i_now_ms;
                n_fcount      = 3'd0;
                n_busy        = 1'b1;
                n_stop_mode   = 1'b1;
                n_await       = 1'b0;
                n_settle      = 1'b0;
                n_status      = ST_WAIT;
            end
            FN_TICK: begin
                if (r_busy) begin
                    if (w_timed_out) begin
                        n_status = ST_FAIL;
                        n_busy   = 1'b0;
                    end else if (i_link_idle) begin
                        if (r_await) begin
                            n_await       = 1'b0;
                            n_frame_stamp = i_now_ms;
                            n_fcount      = w_fcount_inc;
                            if (w_last_frame) begin
                                n_settle = 1'b1;
                            end
                        end else if (r_settle) begin
                            if (w_settle_done) begin
                                n_busy   = 1'b0;
                                n_status = ST_OK;
                            end
                        end else if (w_gap_ok && i_tx_accept) begin
                            n_await = 1'b1;
                            w_kind  = w_frame_kind;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // job for the back end
    always_comb begin
        o_job.kind     = w_kind;
        o_job.dir      = r_rev;
        o_job.status   = n_status;
        o_job.busy     = n_busy;
        o_job.accepted = w_accepted;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_stop_mode   <= 1'b0;
            r_await       <= 1'b0;
            r_settle      <= 1'b0;
            r_rev         <= 1'b0;
            r_fcount      <= 3'd0;
            r_start_stamp <= 32'd0;
            r_frame_stamp <= 32'd0;
            r_status      <= ST_WAIT;
        end else if (w_take) begin
            r_busy        <= n_busy;
            r_stop_mode   <= n_stop_mode;
            r_await       <= n_await;
            r_settle      <= n_settle;
            r_rev         <= n_rev;
            r_fcount      <= n_fcount;
            r_start_stamp <= n_start_stamp;
            r_frame_stamp <= n_frame_stamp;
            r_status      <= n_status;
        end
    end

endmodule

### rtl/core/stcs_back.sv
module stcs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stcs_pkg::t_job     i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    input  logic [7:0]         i_motor_address,
    input  logic [15:0]        i_move_speed,
    input  logic [31:0]        i_move_pulses,
    output stcs_pkg::t_res     o_res,
    output logic               o_res_push,
    input  logic               i_res_full
);
    import stcs_pkg::*;

    logic [3:0] r_idx;
    logic [3:0] w_len;
    logic       w_last, w_frame;

    assign w_len      = frame_len(i_job.kind);
    assign w_last     = (r_idx == w_len - 4'd1);
    assign w_frame    = (i_job.kind != KIND_NONE);
    assign o_res_push = !i_job_empty && !i_res_full;
    assign o_job_pop  = o_res_push && w_last;

    // one result per cycle from the head job while the result queue has room
    always_comb begin
        o_res.frame_byte     = w_frame ? frame_byte(i_job.kind, r_idx, i_motor_address,
                                                    i_job.dir, i_move_speed, i_move_pulses)
                                       : B_ZERO;
        o_res.byte_valid     = w_frame;
        o_res.last_item      = w_last;
        o_res.status         = i_job.status;
        o_res.start_accepted = i_job.accepted;
        o_res.busy_res       = i_job.busy;
    end

    // byte index within the current frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 4'd0;
        end else if (o_res_push) begin
            r_idx <= w_last ? 4'd0 : r_idx + 4'd1;
        end
    end

endmodule

### rtl/core/stepper_turntable_command_sequencer_top.sv
// Stepper turntable command sequencer. Commands (start, stop, tick) enter
// through a push/full queue port; the front end applies each one to the
// move/stop sequencer and posts a job to a short job queue, and the back
// end turns each job into results: one status result, or one result per
// frame byte (enable 6, stop 5, sync 4, position 13). A command is
// accepted every cycle while the job queue has room. The back end emits
// one result per cycle into an output queue while it has room, and pops
// a job only with its last result, at most 13 per job. No clearing pass
// after reset. Registers are written over the APB port at byte address
// 4*index and read back there.
module stepper_turntable_command_sequencer_top #(
    parameter int JOB_DEPTH = stcs_pkg::STCS_JOB_DEPTH,
    parameter int OUT_DEPTH = stcs_pkg::STCS_OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command queue
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic        i_reverse,
    input  logic [31:0] i_now_ms,
    input  logic        i_link_idle,
    input  logic        i_tx_accept,
    // result queue
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_byte_valid,
    output logic        o_last_item,
    output logic [1:0]  o_status,
    output logic        o_start_accepted,
    output logic        o_busy_res,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import stcs_pkg::*;

    logic [15:0] r_timeout_ms, r_travel_settle_ms, r_stop_settle_ms, r_move_speed;
    logic [7:0]  r_frame_gap_ms, r_motor_address;
    logic [31:0] r_move_pulses;
    logic [2:0]  w_reg_idx;
    logic        w_cfg_wr;

    t_job w_job_in, w_job_out;
    t_res w_res_in, w_res_out;
    logic w_job_push, w_job_full, w_job_empty, w_job_pop;
    logic w_res_push, w_res_full;

    // config registers
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms       <= RST_TIMEOUT;
            r_travel_settle_ms <= RST_TRAVEL;
            r_stop_settle_ms   <= RST_STOPSET;
            r_frame_gap_ms     <= RST_GAP;
            r_motor_address    <= RST_ADDR;
            r_move_speed       <= RST_SPEED;
            r_move_pulses      <= RST_PULSES;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_TIMEOUT: r_timeout_ms       <= pwdata[15:0];
                REG_TRAVEL:  r_travel_settle_ms <= pwdata[15:0];
                REG_STOPSET: r_stop_settle_ms   <= pwdata[15:0];
                REG_GAP:     r_frame_gap_ms     <= pwdata[7:0];
                REG_ADDR:    r_motor_address    <= pwdata[7:0];
                REG_SPEED:   r_move_speed       <= pwdata[15:0];
                REG_PULSES:  r_move_pulses      <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            REG_TIMEOUT: prdata = {16'd0, r_timeout_ms};
            REG_TRAVEL:  prdata = {16'd0, r_travel_settle_ms};
            REG_STOPSET: prdata = {16'd0, r_stop_settle_ms};
            REG_GAP:     prdata = {24'd0, r_frame_gap_ms};
            REG_ADDR:    prdata = {24'd0, r_motor_address};
            REG_SPEED:   prdata = {16'd0, r_move_speed};
            REG_PULSES:  prdata = r_move_pulses;
            default:     prdata = 32'd0;
        endcase
    end

    // front: accept and classify commands
    stcs_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_func             (i_func),
        .i_reverse          (i_reverse),
        .i_now_ms           (i_now_ms),
        .i_link_idle        (i_link_idle),
        .i_tx_accept        (i_tx_accept),
        .i_timeout_ms       (r_timeout_ms),
        .i_travel_settle_ms (r_travel_settle_ms),
        .i_stop_settle_ms   (r_stop_settle_ms),
        .i_frame_gap_ms     (r_frame_gap_ms),
        .o_job              (w_job_in),
        .o_job_push         (w_job_push),
        .i_job_full         (w_job_full)
    );

    // job queue between front and back
    stcs_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    // back: frame serializer
    stcs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (w_job_out),
        .i_job_empty     (w_job_empty),
        .o_job_pop       (w_job_pop),
        .i_motor_address (r_motor_address),
        .i_move_speed    (r_move_speed),
        .i_move_pulses   (r_move_pulses),
        .o_res           (w_res_in),
        .o_res_push      (w_res_push),
        .i_res_full      (w_res_full)
    );

    // result queue
    stcs_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_frame_byte     = w_res_out.frame_byte;
    assign o_byte_valid     = w_res_out.byte_valid;
    assign o_last_item      = w_res_out.last_item;
    assign o_status         = w_res_out.status;
    assign o_start_accepted = w_res_out.start_accepted;
    assign o_busy_res       = w_res_out.busy_res;

endmodule

### rtl/core/stcs_checker.sv
module stcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic [7:0] o_frame_byte,
    input logic       o_byte_valid,
    input logic       o_last_item,
    input logic [1:0] o_status,
    input logic       o_start_accepted,
    input logic       o_busy_res
);
    import stcs_pkg::*;

    // result queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a status-only result carries a zero byte and ends its request
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> (o_frame_byte == B_ZERO && o_last_item))
        else $error("status-only result malformed");

    // an accepted start leaves a pending operation in waiting state
    a_start_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_start_accepted) |->
            (!o_byte_valid && o_busy_res && o_status == ST_WAIT))
        else $error("accepted start with wrong status");

    // ok or failed means no operation is pending
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ST_OK || o_status == ST_FAIL)) |-> !o_busy_res)
        else $error("final status while busy");

endmodule

bind stepper_turntable_command_sequencer_top stcs_checker u_stcs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .o_frame_byte     (o_frame_byte),
    .o_byte_valid     (o_byte_valid),
    .o_last_item      (o_last_item),
    .o_status         (o_status),
    .o_start_accepted (o_start_accepted),
    .o_busy_res       (o_busy_res)
);
